@@ rtl/core/pbd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the planar PackBits image decoder.
// Holds the sequencer state type and the codes shared by the top level and the bench.
package pbd_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MERGE,
        S_CONV,
        S_EMIT
    } pbd_state_t;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_START   = 2'd2;

    localparam logic [1:0] MODE_RGB     = 2'd0;
    localparam logic [1:0] MODE_CMYK    = 2'd1;
    localparam logic [1:0] MODE_INDEXED = 2'd2;
    localparam logic [1:0] MODE_GRAY    = 2'd3;

    localparam logic [2:0] REG_COLOR_MODE    = 3'd0;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_COMPRESSED    = 3'd4;

    localparam int PAL_SIZE   = 768;
    localparam int PAL_PLANE  = PAL_SIZE / 3;
    localparam logic [7:0] PB_NOP = 8'd128;

endpackage

@@ rtl/core/pbd_ram.sv @@
`timescale 1ns / 1ps
// Generic single write, single read RAM with a registered read port.
// Used for the frame store and the palette planes; no dependencies.
module pbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/packbits_plane_image_decoder_unit.sv @@
`timescale 1ns / 1ps
// Planar PackBits image decoder: top level with sequencer, frame store and palette.
// Depends on pbd_pkg and pbd_ram.
// Header, skipped and ignored beats are taken in the idle state. A beat that stores
// pixels blocks the input until each pixel has gone through one read-merge-write of the
// single frame store port and, on the last plane, conversion and pair output, which can
// be stalled by the output. After reset and after every start-of-image beat a clearing
// pass writes all ones to the whole frame store, during which no beat is accepted.
module packbits_plane_image_decoder_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // byte_value, palette_index, zero fill
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // pixel_row, pixel_column, pixel_count,
                                        // first_pixel, second_pixel, zero fill
    output logic        m_axis_tlast
);

    import pbd_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 129);
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SKW   = $clog2(MAX_HEIGHT + 1) + 4;

    pbd_state_t state_reg, state_next;

    logic [1:0]  color_mode_reg;
    logic [2:0]  channel_count_reg;
    logic [8:0]  image_width_reg;
    logic [8:0]  image_height_reg;
    logic        compressed_reg;

    logic [1:0]     plane_reg;
    logic [RW-1:0]  row_reg;
    logic [CW-1:0]  col_reg;
    logic [1:0]     phase_reg;
    logic [7:0]     run_reg;
    logic [SKW-1:0] skip_reg;
    logic           done_reg;
    logic [AW-1:0]  clr_cnt_reg;

    logic [XW-1:0]  cur_reg;
    logic [XW:0]    end_reg;
    logic [RW-1:0]  run_row_reg;
    logic [1:0]     run_plane_reg;
    logic           run_last_reg;
    logic [7:0]     value_reg;
    logic [31:0]    merged_reg;
    logic           have_first_reg;
    logic [31:0]    first_reg;
    logic [XW-1:0]  first_col_reg;
    logic [31:0]    pend_second_reg;
    logic [1:0]     pend_count_reg;
    logic           pend_last_reg;

    logic           out_valid_reg;
    logic [87:0]    out_data_reg;
    logic           out_last_reg;

    logic [1:0] in_kind;
    logic [7:0] in_byte;
    logic [9:0] in_pidx;
    logic       in_acc;
    logic       emit_ok;
    logic       at_end;

    logic [12:0] eff_w;
    logic [12:0] eff_h;
    logic [2:0]  passes;

    logic          fs_we;
    logic [AW-1:0] fs_waddr;
    logic [31:0]   fs_wdata;
    logic [AW-1:0] fs_raddr;
    logic [31:0]   fs_rdata;
    logic [2:0]    pal_we;
    logic [7:0]    pal_rdata [3];

    // Decode results for the beat at the input.
    logic [1:0]     d_plane;
    logic [RW-1:0]  d_row;
    logic [CW-1:0]  d_col;
    logic [1:0]     d_phase;
    logic [7:0]     d_run;
    logic [SKW-1:0] d_skip;
    logic           d_done;
    logic           d_store;
    logic [7:0]     d_len;
    logic [CW:0]    d_sum;
    logic [XW:0]    d_end;

    logic [31:0] merged_now;
    logic [31:0] conv_px;

    assign in_kind = s_axis_tuser;
    assign in_byte = s_axis_tdata[7:0];
    assign in_pidx = s_axis_tdata[17:8];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign emit_ok = !out_valid_reg || m_axis_tready;
    assign at_end  = ((XW + 1)'(cur_reg) + (XW + 1)'(1)) == end_reg;

    always_comb
    begin
        if (image_width_reg == 9'd0)
        begin
            eff_w = 13'd1;
        end
        else if (13'(image_width_reg) > 13'(MAX_WIDTH))
        begin
            eff_w = 13'(MAX_WIDTH);
        end
        else
        begin
            eff_w = 13'(image_width_reg);
        end
        if (image_height_reg == 9'd0)
        begin
            eff_h = 13'd1;
        end
        else if (13'(image_height_reg) > 13'(MAX_HEIGHT))
        begin
            eff_h = 13'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = 13'(image_height_reg);
        end
        if (channel_count_reg == 3'd0)
        begin
            passes = 3'd1;
        end
        else if (channel_count_reg >= 3'd5)
        begin
            passes = 3'd4;
        end
        else
        begin
            passes = channel_count_reg;
        end
    end

    // PackBits decode of one data beat and the row and plane advance.
    always_comb
    begin
        d_plane = plane_reg;
        d_row   = row_reg;
        d_col   = col_reg;
        d_phase = phase_reg;
        d_run   = run_reg;
        d_skip  = skip_reg;
        d_done  = done_reg;
        d_store = 1'b0;
        d_len   = 8'd1;
        if (skip_reg != '0)
        begin
            d_skip = skip_reg - 1'b1;
        end
        else
        begin
            if (!compressed_reg)
            begin
                d_phase = 2'd0;
                d_run   = 8'd0;
                d_store = 1'b1;
                d_col   = col_reg + 1'b1;
            end
            else if (phase_reg == 2'd1)
            begin
                d_store = 1'b1;
                d_len   = run_reg;
                d_col   = col_reg + CW'(run_reg);
                d_run   = 8'd0;
                d_phase = 2'd0;
            end
            else if (phase_reg == 2'd2)
            begin
                d_store = 1'b1;
                d_col   = col_reg + 1'b1;
                if (run_reg > 8'd1)
                begin
                    d_run = run_reg - 1'b1;
                end
                else
                begin
                    d_run   = 8'd0;
                    d_phase = 2'd0;
                end
            end
            else if (in_byte > PB_NOP)
            begin
                d_run   = 8'(9'd257 - 9'(in_byte));
                d_phase = 2'd1;
            end
            else if (in_byte < PB_NOP)
            begin
                d_run   = in_byte + 1'b1;
                d_phase = 2'd2;
            end
            if (d_phase == 2'd0 && 13'(d_col) >= eff_w)
            begin
                d_col = '0;
                if (13'(row_reg) + 13'd1 >= eff_h)
                begin
                    d_row = '0;
                    if (3'(plane_reg) + 3'd1 >= passes)
                    begin
                        d_plane = 2'd0;
                        d_done  = 1'b1;
                    end
                    else
                    begin
                        d_plane = plane_reg + 1'b1;
                    end
                end
                else
                begin
                    d_row = row_reg + 1'b1;
                end
            end
        end
        d_sum = (CW + 1)'(col_reg) + (CW + 1)'(d_len);
        if (13'(d_sum) > eff_w)
        begin
            d_end = (XW + 1)'(eff_w);
        end
        else
        begin
            d_end = (XW + 1)'(d_sum);
        end
        if ((CW + 1)'(d_end) <= (CW + 1)'(col_reg))
        begin
            d_store = 1'b0;
        end
    end

    always_comb
    begin
        merged_now = fs_rdata;
        for (int p = 0; p < 4; p++)
        begin
            if (run_plane_reg == 2'(p))
            begin
                merged_now[8*p +: 8] = value_reg;
            end
        end
    end

    always_comb
    begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic [15:0] pr;
        logic [15:0] pg;
        logic [15:0] pb;
        r  = merged_reg[7:0];
        g  = merged_reg[15:8];
        b  = merged_reg[23:16];
        a  = merged_reg[31:24];
        pr = r * a;
        pg = g * a;
        pb = b * a;
        unique case (color_mode_reg)
            MODE_CMYK:
            begin
                r = pr[15:8];
                g = pg[15:8];
                b = pb[15:8];
                if (channel_count_reg == 3'd4)
                begin
                    a = 8'hff;
                end
            end
            MODE_INDEXED:
            begin
                r = pal_rdata[0];
                g = pal_rdata[1];
                b = pal_rdata[2];
                a = 8'hff;
            end
            MODE_GRAY:
            begin
                g = r;
                b = r;
                a = 8'hff;
            end
            MODE_RGB:
            begin
            end
        endcase
        conv_px = {a, b, g, r};
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc && in_kind == KIND_START)
                begin
                    state_next = S_CLEAR;
                end
                else if (in_acc && in_kind == KIND_DATA && !done_reg && d_store)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (run_last_reg)
                begin
                    state_next = S_CONV;
                end
                else if (at_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_CONV:
            begin
                if (have_first_reg || at_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = pend_last_reg ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        fs_we         = 1'b0;
        fs_waddr      = clr_cnt_reg;
        fs_wdata      = '1;
        pal_we        = 3'b000;
        unique case (state_reg)
            S_CLEAR:
            begin
                fs_we = 1'b1;
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_acc && in_kind == KIND_PALETTE && in_pidx < 10'(PAL_SIZE))
                begin
                    pal_we[in_pidx[9:8]] = 1'b1;
                end
            end
            S_MERGE:
            begin
                fs_we    = 1'b1;
                fs_waddr = fs_raddr;
                fs_wdata = merged_now;
            end
            S_READ, S_CONV, S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign fs_raddr = AW'(run_row_reg) * AW'(MAX_WIDTH) + AW'(cur_reg);

    pbd_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_pal
        pbd_ram #(
            .WIDTH (8),
            .DEPTH (PAL_PLANE)
        ) u_pal (
            .clk   (clk),
            .we    (pal_we[k]),
            .waddr (in_pidx[7:0]),
            .wdata (in_byte),
            .raddr (merged_now[7:0]),
            .rdata (pal_rdata[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_cnt_reg       <= '0;
            color_mode_reg    <= MODE_RGB;
            channel_count_reg <= 3'd4;
            image_width_reg   <= 9'd256;
            image_height_reg  <= 9'd256;
            compressed_reg    <= 1'b1;
            plane_reg         <= 2'd0;
            row_reg           <= '0;
            col_reg           <= '0;
            phase_reg         <= 2'd0;
            run_reg           <= 8'd0;
            skip_reg          <= '0;
            done_reg          <= 1'b0;
            have_first_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_COLOR_MODE:    color_mode_reg    <= cfg_data[1:0];
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[2:0];
                    REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                    REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                    REG_COMPRESSED:    compressed_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == S_IDLE && in_acc && in_kind == KIND_START)
            begin
                clr_cnt_reg <= '0;
                plane_reg   <= 2'd0;
                row_reg     <= '0;
                col_reg     <= '0;
                phase_reg   <= 2'd0;
                run_reg     <= 8'd0;
                done_reg    <= 1'b0;
                skip_reg    <= compressed_reg
                             ? SKW'(14'(eff_h) * 14'(channel_count_reg)) << 1 : '0;
            end
            if (state_reg == S_IDLE && in_acc && in_kind == KIND_DATA && !done_reg)
            begin
                plane_reg <= d_plane;
                row_reg   <= d_row;
                col_reg   <= d_col;
                phase_reg <= d_phase;
                run_reg   <= d_run;
                skip_reg  <= d_skip;
                done_reg  <= d_done;
            end
            if (state_reg == S_EMIT && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_CONV)
            begin
                have_first_reg <= !(have_first_reg || at_end);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_acc)
        begin
            cur_reg       <= XW'(col_reg);
            end_reg       <= d_end;
            run_row_reg   <= row_reg;
            run_plane_reg <= plane_reg;
            run_last_reg  <= (3'(plane_reg) + 3'd1) == passes;
            value_reg     <= in_byte;
        end
        if (state_reg == S_MERGE)
        begin
            merged_reg <= merged_now;
            if (!run_last_reg)
            begin
                cur_reg <= cur_reg + 1'b1;
            end
        end
        if (state_reg == S_CONV)
        begin
            pend_last_reg <= at_end;
            if (!have_first_reg)
            begin
                first_reg       <= conv_px;
                first_col_reg   <= cur_reg;
                pend_second_reg <= '0;
                pend_count_reg  <= 2'd1;
                if (!at_end)
                begin
                    cur_reg <= cur_reg + 1'b1;
                end
            end
            else
            begin
                pend_second_reg <= conv_px;
                pend_count_reg  <= 2'd2;
            end
        end
        if (state_reg == S_EMIT && emit_ok)
        begin
            out_data_reg <= {6'd0, pend_second_reg, first_reg, pend_count_reg,
                             8'(first_col_reg), 8'(run_row_reg)};
            out_last_reg <= pend_last_reg;
            if (!pend_last_reg)
            begin
                cur_reg <= cur_reg + 1'b1;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !s_axis_tready)
        else $error("beat accepted during frame store clear");

    a_emit_last_plane: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> run_last_reg)
        else $error("pixel emitted outside the last plane");

    a_cur_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> (XW + 1)'(cur_reg) < end_reg)
        else $error("frame store read beyond run end");

    a_merge_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MERGE |-> $past(state_reg) == S_READ)
        else $error("merge without a preceding frame store read");

endmodule

@@ bench/tb_packbits_plane_image_decoder_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the planar PackBits image decoder: queued stimulus, a clocked
// driver and monitor, and a bit-true predictor of the frame store and pixel conversion.
// Depends on pbd_pkg and the packbits_plane_image_decoder_unit RTL.
module tb_packbits_plane_image_decoder_unit;
    import pbd_pkg::*;

    localparam logic [1:0] KIND_BAD = 2'd3;
    localparam int FS_W = 256;
    localparam int FS_H = 256;
    localparam longint CYCLE_LIMIT = 8000000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [9:0] pal_addr;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [1:0]  cnt;
        logic [31:0] first_px;
        logic [31:0] second_px;
        logic        last;
    } pix_pair_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    in_beat_t  pending_beats[$];
    pix_pair_t expected_pairs[$];
    int        error_count;
    longint    cycle_count;
    bit        calm_tx;
    bit        calm_rx;

    // Shadow configuration and decoder state.
    logic [1:0]  sh_mode;
    logic [2:0]  sh_channels;
    logic [8:0]  sh_width;
    logic [8:0]  sh_height;
    logic        sh_packed;
    logic [31:0] frame_px[FS_W * FS_H];
    logic [7:0]  palette[PAL_SIZE];
    int          plane, row, col, phase, run_left, skip_left;
    bit          image_done;

    packbits_plane_image_decoder_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int pass_total();
        if (sh_channels == 3'd0)
            return 1;
        if (sh_channels >= 3'd5)
            return 4;
        return int'(sh_channels);
    endfunction

    function automatic logic [31:0] to_rgba(logic [31:0] px);
        logic [7:0] r, g, b, a;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        a = px[31:24];
        case (sh_mode)
            MODE_CMYK:
            begin
                r = 8'((16'(r) * 16'(a)) >> 8);
                g = 8'((16'(g) * 16'(a)) >> 8);
                b = 8'((16'(b) * 16'(a)) >> 8);
                if (sh_channels == 3'd4)
                    a = 8'hff;
            end
            MODE_INDEXED:
            begin
                g = palette[int'(r) + PAL_PLANE];
                b = palette[int'(r) + 2 * PAL_PLANE];
                r = palette[int'(r)];
                a = 8'hff;
            end
            MODE_GRAY:
            begin
                g = r;
                b = r;
                a = 8'hff;
            end
            default: ;
        endcase
        return {a, b, g, r};
    endfunction

    // Writes one plane byte into a clamped span of the current row; emits pairs on the
    // last plane.
    function automatic void paint_span(int start, int len, logic [7:0] value);
        int        stop;
        int        c;
        pix_pair_t pr;
        stop = start + len;
        if (stop > int'(sh_width))
            stop = int'(sh_width);
        for (c = start; c < stop; c++)
            frame_px[row * FS_W + c][plane * 8 +: 8] = value;
        if (plane != pass_total() - 1)
            return;
        for (c = start; c < stop; c += 2)
        begin
            pr.row = 8'(row);
            pr.col = 8'(c);
            pr.cnt = (c + 1 < stop) ? 2'd2 : 2'd1;
            pr.first_px = to_rgba(frame_px[row * FS_W + c]);
            pr.second_px = (pr.cnt == 2'd2) ? to_rgba(frame_px[row * FS_W + c + 1]) : 32'd0;
            pr.last = (c + 2 >= stop);
            expected_pairs.push_back(pr);
        end
    endfunction

    function automatic void next_row_if_full();
        if (col < int'(sh_width))
            return;
        col = 0;
        row++;
        if (row >= int'(sh_height))
        begin
            row = 0;
            plane++;
            if (plane >= pass_total())
            begin
                plane = 0;
                image_done = 1'b1;
            end
        end
    endfunction

    function automatic void predict_decode(in_beat_t bt);
        int i;
        if (bt.kind == KIND_PALETTE)
        begin
            if (bt.pal_addr < PAL_SIZE)
                palette[bt.pal_addr] = bt.value;
            return;
        end
        if (bt.kind == KIND_START)
        begin
            for (i = 0; i < FS_W * FS_H; i++)
                frame_px[i] = 32'hffff_ffff;
            plane = 0;
            row = 0;
            col = 0;
            phase = 0;
            run_left = 0;
            skip_left = sh_packed ? 2 * int'(sh_height) * int'(sh_channels) : 0;
            image_done = 1'b0;
            return;
        end
        if (bt.kind != KIND_DATA || image_done)
            return;
        if (skip_left > 0)
        begin
            skip_left--;
            return;
        end
        if (!sh_packed)
        begin
            phase = 0;
            run_left = 0;
            paint_span(col, 1, bt.value);
            col++;
            next_row_if_full();
            return;
        end
        if (phase == 1)
        begin
            paint_span(col, run_left, bt.value);
            col += run_left;
            run_left = 0;
            phase = 0;
        end
        else if (phase == 2)
        begin
            paint_span(col, 1, bt.value);
            col++;
            if (run_left > 0)
                run_left--;
            if (run_left == 0)
                phase = 0;
        end
        else if (bt.value > PB_NOP)
        begin
            run_left = 257 - int'(bt.value);
            phase = 1;
        end
        else if (bt.value < PB_NOP)
        begin
            run_left = int'(bt.value) + 1;
            phase = 2;
        end
        if (phase == 0)
            next_row_if_full();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    task automatic add_beat(logic [1:0] kind, logic [7:0] value, logic [9:0] pal_addr);
        in_beat_t bt;
        bt.kind = kind;
        bt.value = value;
        bt.pal_addr = pal_addr;
        pending_beats.push_back(bt);
    endtask

    task automatic add_data(logic [7:0] value);
        add_beat(KIND_DATA, value, 10'($urandom));
    endtask

    task automatic add_noise();
        if ($urandom_range(0, 1))
            add_beat(KIND_BAD, 8'($urandom), 10'($urandom));
        else
            add_beat(KIND_PALETTE, 8'($urandom), 10'($urandom_range(768, 1023)));
    endtask

    task automatic add_packets(int n);
        int k, j, hdr;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0: add_data(PB_NOP);
                1, 2, 3, 4:
                begin
                    hdr = $urandom_range(0, 5) == 0 ? 129 : $urandom_range(250, 255);
                    add_data(8'(hdr));
                    add_data(8'($urandom));
                end
                5, 6, 7, 8:
                begin
                    hdr = $urandom_range(0, 6);
                    add_data(8'(hdr));
                    for (j = 0; j <= hdr; j++)
                        add_data(8'($urandom));
                end
                default: add_noise();
            endcase
        end
    endtask

    task automatic add_raw(int n, int top);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                add_noise();
            add_data(8'($urandom_range(0, top)));
        end
    endtask

    task automatic add_skip();
        int k;
        if (sh_packed)
            for (k = 0; k < 2 * int'(sh_height) * int'(sh_channels); k++)
                add_data(8'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_pairs.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [8:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_COLOR_MODE:    sh_mode = value[1:0];
            REG_CHANNEL_COUNT: sh_channels = value[2:0];
            REG_IMAGE_WIDTH:   sh_width = value;
            REG_IMAGE_HEIGHT:  sh_height = value;
            default:           sh_packed = value[0];
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic new_image(logic [1:0] mode, int chans, int w, int h, bit pk);
        wait_idle();
        write_reg(REG_COLOR_MODE, 9'(mode));
        write_reg(REG_CHANNEL_COUNT, 9'(chans));
        write_reg(REG_IMAGE_WIDTH, 9'(w));
        write_reg(REG_IMAGE_HEIGHT, 9'(h));
        write_reg(REG_COMPRESSED, 9'(pk));
        calm_tx = ($urandom_range(0, 3) == 0);
        calm_rx = ($urandom_range(0, 3) == 0);
        add_beat(KIND_START, 8'($urandom), 10'($urandom));
        add_skip();
    endtask

    // Driver: presents queued beats with random gaps and updates the predictor on
    // every accepted beat.
    int tx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_decode({s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[17:8]});
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    in_beat_t bt;
                    bt = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= bt.kind;
                    s_axis_tdata <= {6'd0, bt.pal_addr, bt.value};
                    if (!calm_tx && $urandom_range(0, 2) == 0)
                        tx_gap = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 3);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and a field-by-field check of each result beat.
    int rx_stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    report_mismatch("unexpected result beat", m_axis_tdata[31:0], 32'd0);
                end
                else
                begin
                    pix_pair_t want;
                    want = expected_pairs.pop_front();
                    if (m_axis_tdata[7:0] !== want.row)
                        report_mismatch("pixel_row", 32'(m_axis_tdata[7:0]), 32'(want.row));
                    if (m_axis_tdata[15:8] !== want.col)
                        report_mismatch("pixel_column", 32'(m_axis_tdata[15:8]),
                                        32'(want.col));
                    if (m_axis_tdata[17:16] !== want.cnt)
                        report_mismatch("pixel_count", 32'(m_axis_tdata[17:16]),
                                        32'(want.cnt));
                    if (m_axis_tdata[49:18] !== want.first_px)
                        report_mismatch("first_pixel", m_axis_tdata[49:18], want.first_px);
                    if (m_axis_tdata[81:50] !== want.second_px)
                        report_mismatch("second_pixel", m_axis_tdata[81:50], want.second_px);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("run_end", 32'(m_axis_tlast), 32'(want.last));
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm_rx && $urandom_range(0, 2) == 0)
            begin
                rx_stall = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_packbits_plane_image_decoder_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        int k;
        error_count = 0;
        cycle_count = 0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sh_mode = MODE_RGB;
        sh_channels = 3'd4;
        sh_width = 9'd256;
        sh_height = 9'd256;
        sh_packed = 1'b1;
        for (k = 0; k < FS_W * FS_H; k++)
            frame_px[k] = 32'hffff_ffff;
        for (k = 0; k < PAL_SIZE; k++)
            palette[k] = 8'd0;
        plane = 0;
        row = 0;
        col = 0;
        phase = 0;
        run_left = 0;
        skip_left = 0;
        image_done = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed image: every header class, clamped runs and beats after completion.
        new_image(MODE_RGB, 3, 2, 2, 1'b1);
        add_data(PB_NOP);
        add_data(8'd255);
        add_data(8'h00);
        add_data(8'd0);
        add_data(8'hff);
        add_data(8'd129);
        add_data(8'h80);
        add_data(8'd254);
        add_data(8'h55);
        add_data(8'd1);
        add_data(8'haa);
        add_data(8'h01);
        add_data(8'd255);
        add_data(8'h12);
        add_data(8'd255);
        add_data(8'h34);
        add_data(8'd7);
        add_beat(KIND_BAD, 8'hff, 10'h3ff);
        add_beat(KIND_PALETTE, 8'h00, 10'd1023);

        // The palette entries that the indexed image reads are written before it starts.
        wait_idle();
        for (k = 0; k < 8; k++)
        begin
            add_beat(KIND_PALETTE, 8'($urandom), 10'(k));
            add_beat(KIND_PALETTE, 8'($urandom), 10'(k + PAL_PLANE));
            add_beat(KIND_PALETTE, 8'($urandom), 10'(k + 2 * PAL_PLANE));
        end
        new_image(MODE_INDEXED, 1, 3, 3, 1'b0);
        add_raw(10, 7);

        new_image(MODE_CMYK, 4, 3, 2, 1'b1);
        add_packets(6);

        new_image(MODE_CMYK, 5, 1, 1, 1'b1);
        add_packets(4);

        // Full-width row: longest repeat, a literal, and a repeat clamped at the row end.
        new_image(MODE_GRAY, 1, 256, 1, 1'b1);
        add_data(8'd129);
        add_data(8'($urandom));
        add_data(8'd6);
        for (k = 0; k < 7; k++)
            add_data(8'($urandom));
        add_data(8'd129);
        add_data(8'($urandom));

        new_image(MODE_RGB, 2, 3, 2, 1'b0);
        add_raw(14, 255);

        new_image(MODE_GRAY, 1, 1, 12, 1'b0);
        add_raw(14, 255);

        new_image(MODE_RGB, 2, 5, 2, 1'b1);
        add_packets(12);

        wait_idle();
        if (error_count == 0)
            $display("tb_packbits_plane_image_decoder_unit: done, clean");
        else
            $display("tb_packbits_plane_image_decoder_unit: done, errors");
        $finish;
    end
endmodule
